FILE: hw/rtl/rolling_window_checksum_core_defines.svh
// ---------------------------------------------------------------------------
// Rolling window checksum assertion macros
// Shared property templates for the checksum core checker.
// ---------------------------------------------------------------------------
`ifndef ROLLING_WINDOW_CHECKSUM_CORE_DEFINES_SVH
`define ROLLING_WINDOW_CHECKSUM_CORE_DEFINES_SVH

// The consequent must hold in the cycle after the antecedent.
`define RWC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rolling window checksum: next-cycle property failed");

// The consequent must hold in the same cycle as the antecedent.
`define RWC_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rolling window checksum: same-cycle property failed");

`endif

FILE: hw/rtl/rwc_pkg.sv
// ---------------------------------------------------------------------------
// Rolling window checksum package
// Widths, reset constants and control bundles shared by the core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package rwc_pkg;

    localparam int BYTE_W = 8;
    localparam int SUM_W  = 16;
    localparam int WLEN_W = 7;
    localparam int PROD_W = BYTE_W + WLEN_W;

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [SUM_W-1:0]  t_sum;
    typedef logic [WLEN_W-1:0] t_wlen;
    typedef logic [PROD_W-1:0] t_prod;

    localparam t_wlen WLEN_RESET = 7'd32;

    typedef struct packed {
        logic  shift;
        t_wlen len_m1;
    } t_cell_ctrl;

    typedef struct packed {
        logic  step;
        logic  rolling;
        logic  clear;
        t_wlen len;
    } t_sum_ctrl;

endpackage

FILE: hw/rtl/rwc_cell.sv
// ---------------------------------------------------------------------------
// Rolling window checksum delay cell
// One byte stage of the window chain; loads the new byte when it is the
// insertion point for the current window length, else takes its neighbor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rwc_cell
    import rwc_pkg::*;
#(
    parameter int INDEX = 0
) (
    input  logic       i_clk,
    input  t_cell_ctrl i_ctrl,
    input  t_byte      i_new_byte,
    input  t_byte      i_next_byte,
    output t_byte      o_byte
);

    localparam t_wlen POS = t_wlen'(INDEX);

    t_byte r_byte;
    t_byte n_byte;

    always_comb begin
        if (i_ctrl.len_m1 == POS) begin
            n_byte = i_new_byte;
        end else begin
            n_byte = i_next_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_byte <= n_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

FILE: hw/rtl/rwc_sum.sv
// ---------------------------------------------------------------------------
// Rolling window checksum sum unit
// Holds the plain and weighted 16-bit sums and computes their next values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rwc_sum
    import rwc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_sum_ctrl i_ctrl,
    input  t_byte     i_new_byte,
    input  t_byte     i_old_byte,
    output t_sum      o_sum_low_next,
    output t_sum      o_sum_wt_next
);

    t_sum  r_sum_low;
    t_sum  r_sum_wt;
    t_sum  n_sum_low;
    t_sum  n_sum_wt;
    t_prod w_prod;
    t_sum  w_new_ext;
    t_sum  w_old_ext;

    assign w_new_ext = {{(SUM_W-BYTE_W){1'b0}}, i_new_byte};
    assign w_old_ext = {{(SUM_W-BYTE_W){1'b0}}, i_old_byte};
    assign w_prod    = {{BYTE_W{1'b0}}, i_ctrl.len} * {{WLEN_W{1'b0}}, i_old_byte};

    always_comb begin
        if (i_ctrl.rolling) begin
            n_sum_low = r_sum_low - w_old_ext + w_new_ext;
            n_sum_wt  = r_sum_wt - {{(SUM_W-PROD_W){1'b0}}, w_prod} + n_sum_low;
        end else begin
            n_sum_low = r_sum_low + w_new_ext;
            n_sum_wt  = r_sum_wt + n_sum_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_low <= '0;
            r_sum_wt  <= '0;
        end else if (i_ctrl.clear) begin
            r_sum_low <= '0;
            r_sum_wt  <= '0;
        end else if (i_ctrl.step) begin
            r_sum_low <= n_sum_low;
            r_sum_wt  <= n_sum_wt;
        end
    end

    assign o_sum_low_next = n_sum_low;
    assign o_sum_wt_next  = n_sum_wt;

endmodule

FILE: hw/rtl/rolling_window_checksum_core.sv
// ---------------------------------------------------------------------------
// Rolling window checksum core
// Results come in the cycle after their byte; one byte per cycle unless stalled.
// The oldest byte is always at the head of a byte chain, so no address search.
// Synchronous active-low reset: window length 32, sums and fill cleared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rolling_window_checksum_core
    import rwc_pkg::*;
#(
    parameter int MAX_WINDOW = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_hash_value,
    output logic        o_window_full
);

    localparam int    NCELL   = (MAX_WINDOW > 127) ? 127 : MAX_WINDOW;
    localparam t_wlen LEN_CAP = t_wlen'(NCELL);

    t_wlen      r_wlen;
    t_wlen      r_fill;
    t_wlen      n_fill;
    t_wlen      w_len;
    logic       w_filling;
    logic       w_accept;
    logic       r_out_valid;
    logic [31:0] r_hash;
    logic       r_full;
    t_cell_ctrl w_cell_ctrl;
    t_sum_ctrl  w_sum_ctrl;
    t_byte      w_cell_byte [NCELL];
    t_sum       w_sum_low_next;
    t_sum       w_sum_wt_next;

    always_comb begin
        if (r_wlen == '0) begin
            w_len = t_wlen'(1);
        end else if (r_wlen > LEN_CAP) begin
            w_len = LEN_CAP;
        end else begin
            w_len = r_wlen;
        end
    end

    assign w_filling = (r_fill < w_len);
    assign n_fill    = w_filling ? (r_fill + t_wlen'(1)) : r_fill;
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_cell_ctrl.shift  = w_accept;
    assign w_cell_ctrl.len_m1 = w_len - t_wlen'(1);

    assign w_sum_ctrl.step    = w_accept;
    assign w_sum_ctrl.rolling = !w_filling;
    assign w_sum_ctrl.clear   = i_cfg_wr_en;
    assign w_sum_ctrl.len     = w_len;

    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        if (g == NCELL - 1) begin : g_tail
            rwc_cell #(
                .INDEX(g)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_cell_ctrl),
                .i_new_byte (i_data_byte),
                .i_next_byte('0),
                .o_byte     (w_cell_byte[g])
            );
        end else begin : g_body
            rwc_cell #(
                .INDEX(g)
            ) u_cell (
                .i_clk      (i_clk),
                .i_ctrl     (w_cell_ctrl),
                .i_new_byte (i_data_byte),
                .i_next_byte(w_cell_byte[g+1]),
                .o_byte     (w_cell_byte[g])
            );
        end
    end

    rwc_sum u_sum (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (w_sum_ctrl),
        .i_new_byte    (i_data_byte),
        .i_old_byte    (w_cell_byte[0]),
        .o_sum_low_next(w_sum_low_next),
        .o_sum_wt_next (w_sum_wt_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen      <= WLEN_RESET;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_wlen <= i_cfg_wr_data;
                r_fill <= '0;
            end else if (w_accept) begin
                r_fill <= n_fill;
            end
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hash <= {w_sum_low_next, w_sum_wt_next};
            r_full <= (n_fill >= w_len);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_hash_value  = r_hash;
    assign o_window_full = r_full;

endmodule

FILE: hw/rtl/rwc_checker.sv
// ---------------------------------------------------------------------------
// Rolling window checksum port checker
// Watches the core's ports and is bound to every instance of the core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rolling_window_checksum_core_defines.svh"

module rwc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_wr_en,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic [7:0]  i_data_byte,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_hash_value
);

    logic        w_in_beat;
    logic        w_out_stall;
    logic        w_restart_beat;
    logic        r_cfg_wr;
    logic [31:0] r_restart_hash;

    assign w_in_beat      = i_in_valid && i_in_ready;
    assign w_out_stall    = i_out_valid && !i_out_ready;
    assign w_restart_beat = r_cfg_wr && w_in_beat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_wr <= 1'b0;
        end else begin
            r_cfg_wr <= i_cfg_wr_en && !w_in_beat;
        end
        r_restart_hash <= {2{8'd0, i_data_byte}};
    end

    // An output beat that is stalled stays offered.
    `RWC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_stall, i_out_valid)

    // Every accepted input beat shows up as an output beat in the next cycle.
    `RWC_ASSERT_NEXT(a_in_to_out, i_clk, i_rst_n, w_in_beat, i_out_valid)

    // Input is ready whenever the output register is empty.
    `RWC_ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !i_out_valid, i_in_ready)

    // The first beat after a window length write starts from cleared sums.
    `RWC_ASSERT_NEXT(a_restart_hash, i_clk, i_rst_n, w_restart_beat, i_hash_value == r_restart_hash)

endmodule

bind rolling_window_checksum_core rwc_checker u_rwc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_wr_en (i_cfg_wr_en),
    .i_in_valid  (i_in_valid),
    .i_in_ready  (o_in_ready),
    .i_data_byte (i_data_byte),
    .i_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .i_hash_value(o_hash_value)
);

FILE: test/rolling_window_checksum_checker.sv
// ---------------------------------------------------------------------------
// Rolling window checksum checker
// Watches the configuration port and both channels of the checksum core. It
// keeps its own window of bytes and both sums, works out the hash and full
// flag of every accepted input beat, and compares each accepted result beat
// with the oldest expected one, field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module rolling_window_checksum_checker
    import rwc_pkg::*;
#(
    parameter int MAX_WINDOW = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [6:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_hash_value,
    input  logic        i_window_full,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    typedef struct packed {
        logic [31:0] hash;
        logic        full;
    } t_digest;

    t_digest     expected_digests[$];
    t_byte       history[MAX_WINDOW];
    t_wlen       window_reg = WLEN_RESET;
    int unsigned head = 0;
    t_wlen       filled = '0;
    t_sum        sum_a = '0;
    t_sum        sum_b = '0;
    int          mismatches = 0;
    int          beats_checked = 0;
    int          outstanding = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = outstanding;
    assign o_checked    = beats_checked;

    function automatic int unsigned effective_span();
        if (window_reg == 0) return 1;
        if (window_reg > MAX_WINDOW) return MAX_WINDOW;
        return window_reg;
    endfunction

    function automatic void restart_sums();
        head   = 0;
        filled = '0;
        sum_a  = '0;
        sum_b  = '0;
    endfunction

    function automatic t_digest absorb_byte(input t_byte b);
        int unsigned len;
        int unsigned slot;
        t_byte       oldest;
        t_prod       weight;
        t_digest     d;
        len = effective_span();
        slot = (head >= len) ? 0 : head;
        oldest = history[slot];
        history[slot] = b;
        slot++;
        head = (slot >= len) ? 0 : slot;
        if (filled < len) begin
            sum_a = sum_a + t_sum'(b);
            sum_b = sum_b + sum_a;
            filled++;
        end else begin
            // The oldest byte leaves: it was counted once in the first sum
            // and once per window position in the second.
            weight = t_prod'(len) * t_prod'(oldest);
            sum_a = sum_a - t_sum'(oldest) + t_sum'(b);
            sum_b = sum_b - t_sum'(weight) + sum_a;
        end
        d.hash = {sum_a, sum_b};
        d.full = (filled >= len);
        return d;
    endfunction

    function automatic void note_failure(input string what, input t_digest want,
                                         input t_digest got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%0t: %s: expected hash %h full %b, got hash %h full %b",
                     $time, what, want.hash, want.full, got.hash, got.full);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_digest got;
        t_digest want;
        if (!i_rst_n) begin
            window_reg = WLEN_RESET;
            restart_sums();
            foreach (history[k]) history[k] = '0;
            expected_digests.delete();
        end else begin
            if (i_cfg_wr_en) begin
                window_reg = i_cfg_wr_data;
                restart_sums();
            end
            if (i_out_valid && i_out_ready) begin
                got.hash = i_hash_value;
                got.full = i_window_full;
                if (expected_digests.size() == 0) begin
                    note_failure("result beat with nothing expected", '0, got);
                end else begin
                    want = expected_digests.pop_front();
                    beats_checked++;
                    if (got.hash !== want.hash) begin
                        note_failure("hash mismatch", want, got);
                    end else if (got.full !== want.full) begin
                        note_failure("full flag mismatch", want, got);
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                expected_digests.push_back(absorb_byte(i_data_byte));
            end
        end
        outstanding <= expected_digests.size();
    end

endmodule

FILE: test/testbench.sv
// ---------------------------------------------------------------------------
// Rolling window checksum testbench
// Streams bytes into the checksum core under many window lengths, from the
// reset length through zero, one, the maximum and values past it, with
// random idle cycles on the input and random stalls on the result side.
// The checker beside the core predicts and compares every result beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import rwc_pkg::*;

    localparam int MAX_WINDOW   = 64;
    localparam int TARGET_BYTES = 1750;
    localparam int CYCLE_LIMIT  = 600000;

    typedef enum {MIX_BYTES, ALL_ONES} t_fill;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    t_wlen       cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    t_byte       data_byte = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] hash_value;
    logic        window_full;

    int fail_count;
    int pending;
    int checked;
    int bytes_sent = 0;
    int settings_used = 0;
    int cycle_count = 0;
    int ready_run = 0;
    int ready_hold = 0;

    t_wlen sweep_lengths[10] = '{7'd127, 7'd64, 7'd65, 7'd63, 7'd0,
                                 7'd1, 7'd2, 7'd96, 7'd33, 7'd64};

    always #10 clk = ~clk;

    rolling_window_checksum_core #(
        .MAX_WINDOW(MAX_WINDOW)
    ) uut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid   (in_valid),
        .o_in_ready   (in_ready),
        .i_data_byte  (data_byte),
        .o_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .o_hash_value (hash_value),
        .o_window_full(window_full)
    );

    rolling_window_checksum_checker #(
        .MAX_WINDOW(MAX_WINDOW)
    ) digest_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_data_byte  (data_byte),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_hash_value (hash_value),
        .i_window_full(window_full),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Result side: runs of ready, mostly short stalls, now and then a long
    // stall or a long run without any.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            ready_run <= 0;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            out_ready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if (ready_run > 0) begin
            out_ready <= 1'b1;
            ready_run <= ready_run - 1;
        end else begin
            out_ready <= 1'b1;
            ready_run <= ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(0, 12);
            ready_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                     : $urandom_range(1, 3);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d beats outstanding",
                     cycle_count, pending);
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int next_gap(input bit quiet);
        int roll;
        if (quiet) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic t_byte pick_byte(input t_fill fill);
        int roll;
        if (fill == ALL_ONES) return 8'hFF;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 8'h00;
        if (roll == 1) return 8'hFF;
        return t_byte'($urandom_range(0, 255));
    endfunction

    // Valid stays high across back-to-back beats and is only raised when low.
    task automatic push_byte(input t_byte b, input bit keep_valid);
        if (!in_valid) in_valid <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (!in_ready);
        if (!keep_valid) in_valid <= 1'b0;
        bytes_sent++;
    endtask

    task automatic set_window(input t_wlen len);
        do @(posedge clk); while (pending != 0);
        repeat (2) @(posedge clk);
        cfg_wr_data <= len;
        cfg_wr_en <= 1'b1;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        settings_used++;
    endtask

    task automatic send_directed(input logic [63:0] bytes, input int count);
        for (int k = 0; k < count; k++) begin
            push_byte(bytes[8*k +: 8], k != count - 1);
        end
    endtask

    task automatic stream_bytes(input int count, input t_fill fill);
        int gap;
        bit quiet;
        quiet = ($urandom_range(0, 3) == 0);
        for (int k = 0; k < count; k++) begin
            gap = next_gap(quiet);
            push_byte(pick_byte(fill), gap == 0 && k != count - 1);
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_phase(input t_wlen len, input t_fill fill);
        int span;
        span = (len == 0) ? 1 : (len > MAX_WINDOW) ? MAX_WINDOW : len;
        set_window(len);
        stream_bytes($urandom_range(span + 1, 2 * span + 40), fill);
    endtask

    initial begin
        t_wlen len;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The reset length of 32 first, then short windows with the extreme
        // byte values, including a zero length that acts as one.
        stream_bytes($urandom_range(40, 90), MIX_BYTES);
        set_window(7'd0);
        send_directed(64'h80_00_FF_FF_00, 5);
        set_window(7'd2);
        send_directed(64'h00_01_FF_FF_FF_FF, 6);
        set_window(7'd1);
        send_directed(64'h55_AA, 2);

        foreach (sweep_lengths[k]) begin
            run_phase(sweep_lengths[k], (k == 1 || k == 9) ? ALL_ONES : MIX_BYTES);
        end
        while (bytes_sent < TARGET_BYTES) begin
            len = t_wlen'($urandom_range(0, 127));
            run_phase(len, ($urandom_range(0, 4) == 0) ? ALL_ONES : MIX_BYTES);
        end

        do @(posedge clk); while (pending != 0);
        repeat (8) @(posedge clk);

        $display("Streamed %0d bytes under %0d window length writes (0 to 127, saturating)",
                 bytes_sent, settings_used);
        $display("Compared %0d result beats, %0d mismatches", checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
